/* rtl/core/wpp_pkg.sv */
package wpp_pkg;

	// field widths
	localparam int POS_W   = 32;
	localparam int GAIN_W  = 32;
	localparam int DUTY_W  = 10;
	localparam int DBAND_W = 16;
	localparam int TERM_W  = 16;
	localparam int FRAC_W  = 24;
	localparam int PROD_W  = 2 * GAIN_W - FRAC_W;
	localparam int CFG_IDX_W = 3;
	localparam int SUM_W   = TERM_W + 2;

	// opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 32'd1509949440;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 32'd168;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 32'd150994944;
	localparam logic [DUTY_W-1:0]  DUTY_LIMIT_RST = 10'd1000;
	localparam logic [DBAND_W-1:0] DEADBAND_RST   = 16'd40;

	// sign and magnitude of the three pid operands
	typedef struct packed {
		logic              err_neg;
		logic [POS_W-1:0]  err_mag;
		logic              int_neg;
		logic [POS_W-1:0]  int_mag;
		logic              dif_neg;
		logic [POS_W-1:0]  dif_mag;
		logic              in_band;
	} operands_t;

endpackage

/* rtl/core/wpp_error.sv */
module wpp_error (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          opcode,
	input  logic [wpp_pkg::POS_W-1:0]     target_position,
	input  logic [wpp_pkg::POS_W-1:0]     measured_position,
	input  logic [wpp_pkg::DBAND_W-1:0]   deadband,
	output wpp_pkg::operands_t            ops
);

	localparam int W = wpp_pkg::POS_W;

	logic [W-1:0] integral_q;
	logic [W-1:0] prev_q;
	logic [W:0]   err_wide;
	logic [W-1:0] err_sat;
	logic [W:0]   int_wide;
	logic [W-1:0] int_sat;
	logic [W:0]   dif_wide;

	function automatic logic [W-1:0] sat_narrow(input logic [W:0] v);
		logic [W-1:0] r;
		if (v[W] != v[W-1]) begin
			r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] magnitude(input logic [W:0] v);
		logic [W:0] n;
		n = v[W] ? (~v + {{W{1'b0}}, 1'b1}) : v;
		return n[W-1:0];
	endfunction

	always_comb begin
		err_wide = {target_position[W-1], target_position}
			- {measured_position[W-1], measured_position};
		err_sat  = sat_narrow(err_wide);
		int_wide = {integral_q[W-1], integral_q} + {err_sat[W-1], err_sat};
		int_sat  = sat_narrow(int_wide);
		dif_wide = {err_sat[W-1], err_sat} - {prev_q[W-1], prev_q};

		ops.err_neg = err_sat[W-1];
		ops.err_mag = magnitude({err_sat[W-1], err_sat});
		ops.int_neg = int_sat[W-1];
		ops.int_mag = magnitude({int_sat[W-1], int_sat});
		ops.dif_neg = dif_wide[W];
		ops.dif_mag = magnitude(dif_wide);
		ops.in_band = ops.err_mag < {{(W-wpp_pkg::DBAND_W){1'b0}}, deadband};
	end

	// history advances once per word leaving the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_q     <= '0;
		end else if (en) begin
			if (opcode == wpp_pkg::OP_START) begin
				integral_q <= '0;
				prev_q     <= '0;
			end else begin
				integral_q <= int_sat;
				prev_q     <= err_sat;
			end
		end
	end

endmodule

/* rtl/core/wpp_term.sv */
module wpp_term (
	input  logic                               clk,
	input  logic                               en,
	input  logic [wpp_pkg::POS_W-1:0]          mag,
	input  logic                               neg,
	input  logic [wpp_pkg::GAIN_W-1:0]         gain,
	output logic signed [wpp_pkg::TERM_W-1:0]  term_val
);

	localparam int PW = wpp_pkg::PROD_W;
	localparam int TW = wpp_pkg::TERM_W;

	logic [2*wpp_pkg::GAIN_W-1:0] prod_c;
	logic [PW-1:0]                prod_s3;
	logic                         neg_s3;

	assign prod_c = mag * gain;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_c[2*wpp_pkg::GAIN_W-1:wpp_pkg::FRAC_W];
			neg_s3  <= neg;
		end
	end

	// truncate toward zero, then saturate to the signed term range
	always_comb begin
		if (neg_s3) begin
			if (prod_s3 > {{(PW-TW){1'b0}}, 1'b1, {(TW-1){1'b0}}}) begin
				term_val = {1'b1, {(TW-1){1'b0}}};
			end else begin
				term_val = $signed(TW'({TW{1'b0}} - prod_s3[TW-1:0]));
			end
		end else begin
			if (prod_s3 > {{(PW-TW+1){1'b0}}, {(TW-1){1'b1}}}) begin
				term_val = {1'b0, {(TW-1){1'b1}}};
			end else begin
				term_val = $signed(prod_s3[TW-1:0]);
			end
		end
	end

endmodule

/* rtl/core/wheel_position_pid_top.sv */
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_ready   | opcode, target_position, measured_position
// out      | output    | out_valid / out_ready | duty, forward, done_res
// cfg      | input     | cfg_we (no ready)     | cfg_index, cfg_data
//
// one word per cycle sustained while out_ready stays high; each word passes these registered stages to out_valid
// (input register, operand stage, multiply stage, result register)
// each stage has its own valid bit, so a stalled result only holds the
// stages behind it once they are full
// arst_n clears valids and pid history and loads the register defaults
module wheel_position_pid_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [wpp_pkg::POS_W-1:0]         target_position,
	input  logic [wpp_pkg::POS_W-1:0]         measured_position,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wpp_pkg::DUTY_W-1:0]        duty,
	output logic                              forward,
	output logic                              done_res,
	// register writes
	input  logic                              cfg_we,
	input  logic [wpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wpp_pkg::GAIN_W-1:0]        cfg_data
);

	localparam int SW = wpp_pkg::SUM_W;
	localparam int TW = wpp_pkg::TERM_W;
	localparam int DW = wpp_pkg::DUTY_W;

	// configuration registers
	logic [wpp_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [wpp_pkg::GAIN_W-1:0]  integ_gain_q;
	logic [wpp_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic [DW-1:0]               duty_limit_q;
	logic [wpp_pkg::DBAND_W-1:0] deadband_q;

	// pipeline
	logic                        valid_s1, valid_s2, valid_s3;
	logic                        op_s1, op_s2, op_s3;
	logic [wpp_pkg::POS_W-1:0]   target_s1, measured_s1;
	wpp_pkg::operands_t          ops_c, ops_s2;
	logic                        in_band_s3;
	logic                        rdy2, rdy3, rdy_out;

	logic signed [TW-1:0]        t_prop, t_integ, t_deriv;
	logic signed [SW-1:0]        sum_c, lim_c, clamp_c;
	logic [SW-1:0]               abs_c;
	logic [DW-1:0]               duty_c;
	logic                        fwd_c, done_c;

	logic                        out_valid_q;
	logic [DW-1:0]               duty_q;
	logic                        forward_q, done_q;

	// register writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= wpp_pkg::PROP_GAIN_RST;
			integ_gain_q <= wpp_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= wpp_pkg::DERIV_GAIN_RST;
			duty_limit_q <= wpp_pkg::DUTY_LIMIT_RST;
			deadband_q   <= wpp_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpp_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				wpp_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				wpp_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				wpp_pkg::REG_DUTY_LIMIT: duty_limit_q <= cfg_data[DW-1:0];
				wpp_pkg::REG_DEADBAND:   deadband_q   <= cfg_data[wpp_pkg::DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage ready: a stage may load when empty or when it empties
	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy3     = !valid_s3 || rdy_out;
	assign rdy2     = !valid_s2 || rdy3;
	assign in_ready = !valid_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (rdy2)     valid_s2 <= valid_s1;
			if (rdy3)     valid_s3 <= valid_s2;
			if (rdy_out)  out_valid_q <= valid_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1       <= opcode;
			target_s1   <= target_position;
			measured_s1 <= measured_position;
		end
	end

	// stage 1 -> 2: error, integral, difference; history moves with the word
	wpp_error u_error (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (valid_s1 && rdy2),
		.opcode            (op_s1),
		.target_position   (target_s1),
		.measured_position (measured_s1),
		.deadband          (deadband_q),
		.ops               (ops_c)
	);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			op_s2  <= op_s1;
			ops_s2 <= ops_c;
		end
	end

	// stage 2 -> 3: three gain multiplies, registered inside each term unit
	always_ff @(posedge clk) begin
		if (rdy3) begin
			op_s3      <= op_s2;
			in_band_s3 <= ops_s2.in_band;
		end
	end

	wpp_term u_prop (
		.clk      (clk),
		.en       (rdy3),
		.mag      (ops_s2.err_mag),
		.neg      (ops_s2.err_neg),
		.gain     (prop_gain_q),
		.term_val (t_prop)
	);

	wpp_term u_integ (
		.clk      (clk),
		.en       (rdy3),
		.mag      (ops_s2.int_mag),
		.neg      (ops_s2.int_neg),
		.gain     (integ_gain_q),
		.term_val (t_integ)
	);

	wpp_term u_deriv (
		.clk      (clk),
		.en       (rdy3),
		.mag      (ops_s2.dif_mag),
		.neg      (ops_s2.dif_neg),
		.gain     (deriv_gain_q),
		.term_val (t_deriv)
	);

	// stage 3 -> out: sum, symmetric clamp, sign/magnitude, start and deadband overrides
	always_comb begin
		sum_c = SW'(t_prop) + SW'(t_integ) + SW'(t_deriv);
		lim_c = $signed({{(SW-DW){1'b0}}, duty_limit_q});
		if (sum_c > lim_c) begin
			clamp_c = lim_c;
		end else if (sum_c < -lim_c) begin
			clamp_c = -lim_c;
		end else begin
			clamp_c = sum_c;
		end
		abs_c = clamp_c[SW-1] ? SW'(-clamp_c) : clamp_c;

		if (op_s3 == wpp_pkg::OP_START) begin
			// start of a move: quiet result
			duty_c = '0;
			fwd_c  = 1'b0;
			done_c = 1'b0;
		end else if (in_band_s3) begin
			// close enough: stop driving, flag done
			duty_c = '0;
			fwd_c  = 1'b0;
			done_c = 1'b1;
		end else begin
			duty_c = abs_c[DW-1:0];
			fwd_c  = clamp_c > $signed({SW{1'b0}});
			done_c = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (rdy_out && valid_s3) begin
			duty_q    <= duty_c;
			forward_q <= fwd_c;
			done_q    <= done_c;
		end
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_q;
	assign forward   = forward_q;
	assign done_res  = done_q;

endmodule

/* rtl/core/wpp_checker.sv */
module wpp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wpp_pkg::DUTY_W-1:0]  duty,
	input logic                        forward,
	input logic                        done_res
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(forward)
			&& $stable(done_res))
		else $error("result changed while stalled");

	// done means no drive
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> duty == '0 && !forward)
		else $error("drive while done");

	// forward drive is never zero duty
	a_fwd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && forward |-> duty != '0)
		else $error("forward with zero duty");

	// no result word while reset is held
	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid in reset");

	// input side never blocked when nothing is in flight ahead of output
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !out_valid ##1 !in_valid && !out_valid ##1
			!in_valid && !out_valid ##1 !in_valid && !out_valid |-> in_ready)
		else $error("input stalled with empty pipe");

endmodule

bind wheel_position_pid_top wpp_checker u_wpp_checker (.*);
